// ===== rtl/ccs_pkg.sv =====
// Shared types, constants and the byte-wide CRC step for the chunked CRC-32 signer.
// No dependencies; every other file refers to it by scoped names.
package ccs_pkg;

  localparam int SIG_BYTES     = 4;
  localparam int BIDX_W        = $clog2(SIG_BYTES);
  localparam int LEN_W         = 31;

  localparam logic [31:0]      CRC_POLY_REFL = 32'hEDB8_8320;
  localparam logic [31:0]      CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0]      CRC_XOROUT    = 32'hFFFF_FFFF;
  localparam logic [LEN_W-1:0] LEN_RESET     = 31'd1048576;
  localparam logic [BIDX_W-1:0] BIDX_LAST    = BIDX_W'(SIG_BYTES - 1);

  // One finished chunk signature on its way to the serialiser
  typedef struct packed {
    logic [31:0] crc;
    logic        eos;
  } sig_entry_t;

  // Push side of the signature queue
  typedef struct packed {
    logic       valid;
    sig_entry_t entry;
  } q_push_t;

  // Pop side of the signature queue
  typedef struct packed {
    logic       valid;
    sig_entry_t entry;
  } q_head_t;

  // Reflected CRC-32 update over one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/ccs_front.sv =====
// Front end: accepts stream bytes, runs the CRC and the chunk count, and pushes
// one signature per closed chunk. Depends on ccs_pkg.
module ccs_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [ccs_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_end_of_stream,
  input  logic                    q_full,
  output ccs_pkg::q_push_t        q_push
);

  logic [ccs_pkg::LEN_W-1:0] len_r;
  logic [ccs_pkg::LEN_W-1:0] bytes_r, bytes_nxt;
  logic [31:0]               crc_r, crc_nxt;
  logic [31:0]               crc_upd;
  logic [31:0]               count;
  logic                      closes;
  logic                      accept;

  // Classify the offered byte: does it close the chunk
  assign crc_upd = ccs_pkg::crc_byte(crc_r, in_data_byte);
  assign count   = {1'b0, bytes_r} + 32'd1;
  assign closes  = in_end_of_stream | (count >= {1'b0, len_r});

  // Stall only a closing byte when the queue has no room
  assign in_ready = ~q_full | ~closes;
  assign accept   = in_valid & in_ready;

  // Push the finished signature
  always_comb begin
    q_push.valid     = accept & closes;
    q_push.entry.crc = crc_upd ^ ccs_pkg::CRC_XOROUT;
    q_push.entry.eos = in_end_of_stream;
  end

  // Advance or restart the chunk
  always_comb begin
    crc_nxt   = crc_r;
    bytes_nxt = bytes_r;
    if (accept) begin
      if (closes) begin
        crc_nxt   = ccs_pkg::CRC_INIT;
        bytes_nxt = '0;
      end else begin
        crc_nxt   = crc_upd;
        bytes_nxt = count[ccs_pkg::LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= ccs_pkg::LEN_RESET;
      crc_r   <= ccs_pkg::CRC_INIT;
      bytes_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
      crc_r   <= crc_nxt;
      bytes_r <= bytes_nxt;
    end
  end

endmodule

// ===== rtl/ccs_queue.sv =====
// Short queue of finished signatures between the front end and the serialiser.
// Depends on ccs_pkg.
module ccs_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ccs_pkg::q_push_t push,
  output logic             full,
  output ccs_pkg::q_head_t head,
  input  logic             pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  ccs_pkg::sig_entry_t slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full       = (cnt_r == CNT_FULL);
  assign head.valid = (cnt_r != '0);
  assign head.entry = slots_r[rd_ptr_r];

  assign do_push = push.valid & ~full;
  assign do_pop  = pop & head.valid;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push.entry;
    end
  end

endmodule

// ===== rtl/ccs_back.sv =====
// Back end: takes signatures from the queue and sends each as four bytes,
// least significant first. Depends on ccs_pkg.
module ccs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ccs_pkg::q_head_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_sig_byte,
  output logic             out_last_of_chunk,
  output logic             out_last_of_stream
);

  logic                      busy_r, busy_nxt;
  logic [31:0]               sig_r, sig_nxt;
  logic                      eos_r, eos_nxt;
  logic [ccs_pkg::BIDX_W-1:0] idx_r, idx_nxt;
  logic                      take, is_last, load;

  assign take    = busy_r & out_ready;
  assign is_last = (idx_r == ccs_pkg::BIDX_LAST);
  // Load a new signature when empty or as the last byte leaves
  assign load    = ~busy_r | (take & is_last);
  assign pop     = load & head.valid;

  always_comb begin
    busy_nxt = busy_r;
    sig_nxt  = sig_r;
    eos_nxt  = eos_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = head.valid;
      sig_nxt  = head.entry.crc;
      eos_nxt  = head.entry.eos;
      idx_nxt  = '0;
    end else if (take) begin
      sig_nxt = sig_r >> 8;
      idx_nxt = idx_r + ccs_pkg::BIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk) begin
    sig_r <= sig_nxt;
    eos_r <= eos_nxt;
  end

  assign out_valid          = busy_r;
  assign out_sig_byte       = sig_r[7:0];
  assign out_last_of_chunk  = is_last;
  assign out_last_of_stream = is_last & eos_r;

endmodule

// ===== rtl/chunked_crc32_signer.sv =====
// Top level of the chunked CRC-32 signer: front end, signature queue, back end.
// Depends on ccs_pkg, ccs_front, ccs_queue and ccs_back.
//
//   channel | ports                                         | handshake
//   --------+-----------------------------------------------+-------------------
//   input   | in_data_byte, in_end_of_stream                | in_valid/in_ready
//   result  | out_sig_byte, out_last_of_chunk, out_last_... | out_valid/out_ready
//   config  | cfg_wr_data (chunk length, 31 bits)           | cfg_wr_en, no wait
//
// One byte is accepted per cycle while in_ready is high; each accepted byte's CRC update is registered.
// A closed chunk yields four result items, one per cycle from the back end while out_ready
// is high, so with short chunks the rate is bounded by the serialiser.
// A closing byte stalls only while the signature queue is full.
// Reset (synchronous, active low) sets chunk length to 1048576 and empties the queue.
module chunked_crc32_signer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [ccs_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_end_of_stream,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_sig_byte,
  output logic                      out_last_of_chunk,
  output logic                      out_last_of_stream
);

  ccs_pkg::q_push_t q_push;
  ccs_pkg::q_head_t q_head;
  logic             q_full;
  logic             q_pop;

  ccs_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .q_full           (q_full),
    .q_push           (q_push)
  );

  ccs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .head  (q_head),
    .pop   (q_pop)
  );

  ccs_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (q_head),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sig_byte       (out_sig_byte),
    .out_last_of_chunk  (out_last_of_chunk),
    .out_last_of_stream (out_last_of_stream)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for chunked_crc32_signer: a directed table, then random byte streams.
// Depends on ccs_pkg and the chunked_crc32_signer RTL; carries its own per-chunk CRC-32 predictor.
module testbench;

  localparam logic [31:0] SIG_POLY      = 32'hEDB8_8320;
  localparam logic [30:0] LEN_AT_RESET  = 31'd1048576;
  localparam logic [30:0] LEN_MAX       = 31'h7FFF_FFFF;
  localparam logic [30:0] LEN_TOP_RANGE = 31'h4000_0000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          RANDOM_ITEMS  = 340;
  localparam int          DIR_ROWS      = 24;

  // One byte on its way in; a typed signature replaces the predicted one when set
  typedef struct packed {
    logic [7:0]  data;
    logic        eos;
    logic        typed;
    logic [31:0] crc;
  } byte_item_t;

  // One signature byte due on the result channel
  typedef struct packed {
    logic [7:0] sig_byte;
    logic       last_chunk;
    logic       last_stream;
  } sig_item_t;

  // Directed stimulus row: optional length write first, then one byte
  typedef struct packed {
    logic        set_len;
    logic [30:0] len;
    logic [7:0]  data;
    logic        eos;
    logic        typed;
    logic [31:0] crc;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  logic [ccs_pkg::LEN_W-1:0] cfg_wr_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                in_data_byte = '0;
  logic                      in_end_of_stream = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [7:0]                out_sig_byte;
  logic                      out_last_of_chunk;
  logic                      out_last_of_stream;

  // Predictor state
  logic [31:0] model_crc = 32'hFFFF_FFFF;
  logic [31:0] model_count = '0;
  logic [30:0] model_len = LEN_AT_RESET;

  byte_item_t byte_feed_q[$];
  sig_item_t  sig_due_q[$];
  byte_item_t cur_item;
  int         gap_left = 0;
  int         burst_left = 1;
  int         fail_count = 0;

  // Receiver state
  logic [15:0] stall_pat = 16'hFFFF;
  logic [3:0]  pat_pos = '0;
  logic        hold_armed = 1'b0;
  logic        hold_started = 1'b0;
  int          hold_left = 0;

  // Known CRC-32 values: single 0xFF, single 0x00 and the "123456789" check string
  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{1'b0, LEN_AT_RESET,  8'hFF, 1'b1, 1'b1, 32'hFF00_0000},
    '{1'b0, LEN_AT_RESET,  8'h00, 1'b1, 1'b1, 32'hD202_EF8D},
    '{1'b0, LEN_AT_RESET,  8'h31, 1'b0, 1'b0, 32'h0},
    '{1'b0, LEN_AT_RESET,  8'h32, 1'b0, 1'b0, 32'h0},
    '{1'b0, LEN_AT_RESET,  8'h33, 1'b0, 1'b0, 32'h0},
    '{1'b0, LEN_AT_RESET,  8'h34, 1'b0, 1'b0, 32'h0},
    '{1'b0, LEN_AT_RESET,  8'h35, 1'b0, 1'b0, 32'h0},
    '{1'b0, LEN_AT_RESET,  8'h36, 1'b0, 1'b0, 32'h0},
    '{1'b0, LEN_AT_RESET,  8'h37, 1'b0, 1'b0, 32'h0},
    '{1'b0, LEN_AT_RESET,  8'h38, 1'b0, 1'b0, 32'h0},
    '{1'b0, LEN_AT_RESET,  8'h39, 1'b1, 1'b1, 32'hCBF4_3926},
    // one-byte chunks, not at end of stream
    '{1'b1, 31'd1,         8'h00, 1'b0, 1'b1, 32'hD202_EF8D},
    '{1'b0, 31'd1,         8'hFF, 1'b0, 1'b1, 32'hFF00_0000},
    // zero length behaves like one
    '{1'b1, 31'd0,         8'hA5, 1'b0, 1'b0, 32'h0},
    '{1'b0, 31'd0,         8'h5A, 1'b1, 1'b0, 32'h0},
    // largest length, then shrink it mid-chunk to the byte count already taken
    '{1'b1, LEN_MAX,       8'h10, 1'b0, 1'b0, 32'h0},
    '{1'b0, LEN_MAX,       8'h20, 1'b0, 1'b0, 32'h0},
    '{1'b1, 31'd2,         8'h30, 1'b0, 1'b0, 32'h0},
    // length of 2^30, closed by end of stream
    '{1'b1, LEN_TOP_RANGE, 8'h01, 1'b0, 1'b0, 32'h0},
    '{1'b0, LEN_TOP_RANGE, 8'h80, 1'b1, 1'b0, 32'h0},
    // full chunk followed by a short final chunk
    '{1'b1, 31'd3,         8'hC3, 1'b0, 1'b0, 32'h0},
    '{1'b0, 31'd3,         8'h3C, 1'b0, 1'b0, 32'h0},
    '{1'b0, 31'd3,         8'h96, 1'b0, 1'b0, 32'h0},
    '{1'b0, 31'd3,         8'h69, 1'b1, 1'b0, 32'h0}
  };

  chunked_crc32_signer i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_end_of_stream   (in_end_of_stream),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sig_byte       (out_sig_byte),
    .out_last_of_chunk  (out_last_of_chunk),
    .out_last_of_stream (out_last_of_stream)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Reflected CRC-32 over one byte, feeding the data bits LSB first
  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] data);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ data[i];
      crc = {1'b0, crc[31:1]} ^ (fb ? SIG_POLY : 32'h0);
    end
    return crc;
  endfunction

  // Absorb one accepted byte; queue the four signature bytes when the chunk closes
  task automatic sign_byte(input byte_item_t it);
    logic [31:0] nxt;
    logic [31:0] sig;
    sig_item_t   r;
    model_crc = crc_step(model_crc, it.data);
    nxt = model_count + 32'd1;
    if (!it.eos && nxt < {1'b0, model_len}) begin
      model_count = nxt;
    end else begin
      sig = it.typed ? it.crc : ~model_crc;
      for (int k = 0; k < 4; k++) begin
        r.sig_byte    = sig[7:0];
        r.last_chunk  = (k == 3);
        r.last_stream = (k == 3) && it.eos;
        sig_due_q.push_back(r);
        sig = sig >> 8;
      end
      model_crc   = 32'hFFFF_FFFF;
      model_count = '0;
    end
  endtask

  // Sender in bursts and gaps, prediction on acceptance, and result checking
  always @(posedge clk) begin
    sig_item_t due;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (sig_due_q.size() == 0) begin
          $error("result item with none due: sig_byte %02h", out_sig_byte);
          fail_count++;
        end else begin
          due = sig_due_q.pop_front();
          if (out_sig_byte !== due.sig_byte) begin
            $error("sig_byte: expected %02h, actual %02h", due.sig_byte, out_sig_byte);
            fail_count++;
          end
          if (out_last_of_chunk !== due.last_chunk) begin
            $error("last_of_chunk: expected %0b, actual %0b", due.last_chunk,
                   out_last_of_chunk);
            fail_count++;
          end
          if (out_last_of_stream !== due.last_stream) begin
            $error("last_of_stream: expected %0b, actual %0b", due.last_stream,
                   out_last_of_stream);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        sign_byte(cur_item);
      end
      // offer the next item unless the current one is still waiting
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_feed_q.size() > 0) begin
          cur_item = byte_feed_q.pop_front();
          in_valid         <= 1'b1;
          in_data_byte     <= cur_item.data;
          in_end_of_stream <= cur_item.eos;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: rotating stall pattern, with one long hold-off when armed
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_armed && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (pat_pos == 4'd0) begin
          case ($urandom_range(0, 3))
            0:       stall_pat = 16'hFFFF;
            1:       stall_pat = 16'($urandom);
            2:       stall_pat = 16'($urandom) | 16'($urandom);
            default: stall_pat = 16'($urandom) & 16'($urandom);
          endcase
        end
        out_ready <= stall_pat[pat_pos];
        pat_pos = pat_pos + 4'd1;
      end
    end
  end

  // Wait until every item is in, every result is out, and the block has gone quiet
  task automatic settle();
    int quiet;
    quiet = 0;
    while (quiet < SETTLE_CYCLES) begin
      @(negedge clk);
      if (byte_feed_q.size() == 0 && !in_valid && sig_due_q.size() == 0) begin
        quiet++;
      end else begin
        quiet = 0;
      end
    end
  endtask

  task automatic write_chunk_length(input logic [30:0] len);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_len = len;
  endtask

  function automatic logic [30:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return 31'd0;
      1:       return LEN_MAX;
      2:       return LEN_TOP_RANGE;
      3:       return LEN_AT_RESET;
      4:       return 31'($urandom);
      5:       return 31'($urandom_range(9, 64));
      default: return 31'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin
    byte_item_t it;
    int         random_items;
    int         n;
    int         eos_div;
    random_items = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].set_len) begin
        settle();
        write_chunk_length(dir_tab[r].len);
      end
      it.data  = dir_tab[r].data;
      it.eos   = dir_tab[r].eos;
      it.typed = dir_tab[r].typed;
      it.crc   = dir_tab[r].crc;
      byte_feed_q.push_back(it);
    end

    // One-byte chunks under a long receiver hold-off, so the input backs up
    settle();
    write_chunk_length(31'd1);
    hold_armed = 1'b1;
    for (int i = 0; i < 40; i++) begin
      it = '{8'($urandom), ($urandom_range(0, 7) == 0), 1'b0, 32'h0};
      byte_feed_q.push_back(it);
    end
    random_items += 40;

    // Random phases: new length each time, streams of random bytes
    while (random_items < RANDOM_ITEMS) begin
      settle();
      write_chunk_length(pick_length());
      n       = $urandom_range(20, 50);
      eos_div = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(4, 16);
      for (int i = 0; i < n; i++) begin
        it = '{8'($urandom), ($urandom_range(1, eos_div) == 1), 1'b0, 32'h0};
        byte_feed_q.push_back(it);
      end
      random_items += n;
    end

    settle();
    if (fail_count == 0) begin
      $display("PASS chunked_crc32_signer");
    end else begin
      $display("FAIL chunked_crc32_signer");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL chunked_crc32_signer");
    $finish;
  end

endmodule
